// ----- src/mau_pkg.sv -----
// Package for the modular arithmetic unit: request and response types,
// operation codes and the reset value of the modulus register. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;

    localparam int unsigned ResW = 30;
    localparam int unsigned WideW = 64;
    localparam logic [ResW-1:0] MODULUS_RESET_VAL = 30'd1000000007;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_NEG = 3'd5,
        OP_RED = 3'd6,
        OP_INV = 3'd7
    } t_op;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [ResW-1:0]  operand_a;
        logic [ResW-1:0]  operand_b;
        logic signed [WideW-1:0] wide_value;
    } t_req;

    typedef struct packed {
        logic [ResW-1:0] result;
        logic            equal;
    } t_rsp;

endpackage
`default_nettype wire

// ----- src/modular_arithmetic_unit_top.sv -----
// Modular arithmetic unit: one restoring divider and one 32x32 multiplier
// shared under a one-hot sequencer. Depends on mau_pkg.
// Start to result strobe: both operands are reduced, then mul adds a multiply and a
// 64-step divider run, reduce a 64-step run, pow a multiply and run for each squaring
// and set exponent bit, div/inverse a divider run per Euclid step. A modulus below two
// strobes next cycle; else busy stays high, one request at a time, until the strobe.
// Reset clears the sequencer and loads the modulus reset value; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit_top
    import mau_pkg::*;
#(
    parameter logic [29:0] MODULUS_RESET = MODULUS_RESET_VAL
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_req        i_req,
    input  wire logic        i_cfg_we,
    input  wire logic [29:0] i_cfg_wdata,
    output logic             o_strobe,
    output t_rsp             o_rsp
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_DIV     = 16'h0002,
        S_RED_B   = 16'h0004,
        S_EXEC    = 16'h0008,
        S_MUL     = 16'h0010,
        S_FIN_REM = 16'h0020,
        S_NEG_REM = 16'h0040,
        S_POW     = 16'h0080,
        S_POW_R   = 16'h0100,
        S_POW_T   = 16'h0200,
        S_EUC     = 16'h0400,
        S_EUC_Q   = 16'h0800,
        S_EUC_U   = 16'h1000,
        S_INV_FIX = 16'h2000,
        S_DIV2    = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret, r_mret, n_mret, r_iret, n_iret;
    logic [2:0]  r_op, n_op;
    logic [29:0] r_a, n_a, r_b, n_b, r_m, r_x, n_x, r_y, n_y;
    logic [29:0] r_pr, n_pr, r_pt, n_pt, r_ea, n_ea, r_eb, n_eb;
    logic [29:0] r_inv, n_inv, r_res, n_res, r_rem, n_rem, r_dvs, n_dvs;
    logic [63:0] r_w, n_w, r_e, n_e, r_dv, n_dv;
    logic signed [31:0] r_u, n_u, r_v, n_v;
    logic [31:0] r_tv, n_tv;
    logic        r_eq, n_eq;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_ovld, n_ovld;
    t_rsp        r_out, n_out;

    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [30:0] rem2;
    logic        ge;
    logic [31:0] umag;
    logic [29:0] fixm;
    logic [63:0] wneg;

    assign mul_p = mul_x * mul_y;
    assign rem2  = {r_rem, r_dv[63]};
    assign ge    = rem2 >= {1'b0, r_dvs};
    assign wneg  = ~r_w + 64'd1;
    assign umag  = (r_u < 0) ? -r_u : r_u;
    assign fixm  = (umag >= {2'b0, r_m}) ? 30'(umag - {2'b0, r_m}) : umag[29:0];

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_mret = r_mret; n_iret = r_iret;
        n_op = r_op; n_a = r_a; n_b = r_b; n_w = r_w; n_x = r_x; n_y = r_y;
        n_pr = r_pr; n_pt = r_pt; n_e = r_e; n_ea = r_ea; n_eb = r_eb;
        n_u = r_u; n_v = r_v; n_tv = r_tv; n_inv = r_inv; n_res = r_res;
        n_eq = r_eq; n_dv = r_dv; n_rem = r_rem; n_dvs = r_dvs; n_cnt = r_cnt;
        n_ovld = 1'b0; n_out = r_out;
        mul_x = {2'b0, r_x};
        mul_y = {2'b0, r_y};
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = i_req.req_type;
                    n_w  = i_req.wide_value;
                    n_b  = i_req.operand_b;
                    if (r_m < 30'd2) begin
                        n_ovld = 1'b1;
                        n_out.result = '0;
                        n_out.equal  = 1'b1;
                    end else begin
                        n_dv = {i_req.operand_a, 34'd0}; n_cnt = 7'd30;
                        n_rem = '0; n_dvs = r_m; n_ret = S_RED_B; n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? 30'(rem2 - {1'b0, r_dvs}) : rem2[29:0];
                n_dv  = {r_dv[62:0], ge};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) n_state = r_ret;
            end
            S_RED_B: begin
                n_a = r_rem;
                n_dv = {r_b, 34'd0}; n_cnt = 7'd30; n_rem = '0; n_dvs = r_m;
                n_ret = S_EXEC; n_state = S_DIV;
            end
            S_EXEC: begin
                n_b  = r_rem;
                n_eq = (r_a == r_rem);
                n_state = S_DONE;
                unique case (t_op'(r_op))
                    OP_ADD: n_res = ({1'b0, r_a} + {1'b0, r_rem} >= {1'b0, r_m}) ?
                                    30'(r_a + r_rem - r_m) : 30'(r_a + r_rem);
                    OP_SUB: n_res = (r_a >= r_rem) ? 30'(r_a - r_rem) :
                                    30'(r_a + r_m - r_rem);
                    OP_NEG: n_res = (r_a == '0) ? '0 : 30'(r_m - r_a);
                    OP_MUL: begin
                        n_x = r_a; n_y = r_rem; n_mret = S_FIN_REM; n_state = S_MUL;
                    end
                    OP_DIV: begin
                        n_ea = r_rem; n_eb = r_m; n_u = 32'sd1; n_v = 32'sd0;
                        n_iret = S_DIV2; n_state = S_EUC;
                    end
                    OP_INV: begin
                        n_ea = r_a; n_eb = r_m; n_u = 32'sd1; n_v = 32'sd0;
                        n_iret = S_DONE; n_state = S_EUC;
                    end
                    OP_POW: begin
                        if (r_a == '0) n_res = '0;
                        else if (r_w[63] || r_w == '0) n_res = 30'd1;
                        else begin
                            n_pr = 30'd1; n_pt = r_a; n_e = r_w; n_state = S_POW;
                        end
                    end
                    OP_RED: begin
                        n_rem = '0; n_dvs = r_m; n_cnt = 7'd64; n_state = S_DIV;
                        n_dv  = r_w[63] ? wneg : r_w;
                        n_ret = r_w[63] ? S_NEG_REM : S_FIN_REM;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MUL: begin
                n_dv = mul_p; n_cnt = 7'd64; n_rem = '0; n_dvs = r_m;
                n_ret = r_mret; n_state = S_DIV;
            end
            S_FIN_REM: begin
                n_res = r_rem; n_state = S_DONE;
            end
            S_NEG_REM: begin
                n_res = (r_rem == '0) ? '0 : 30'(r_m - r_rem); n_state = S_DONE;
            end
            S_POW: begin
                if (r_e == '0) begin
                    n_res = r_pr; n_state = S_DONE;
                end else if (r_e[0]) begin
                    n_x = r_pr; n_y = r_pt; n_mret = S_POW_R; n_state = S_MUL;
                end else begin
                    n_x = r_pt; n_y = r_pt; n_mret = S_POW_T; n_state = S_MUL;
                end
            end
            S_POW_R: begin
                n_pr = r_rem; n_x = r_pt; n_y = r_pt; n_mret = S_POW_T; n_state = S_MUL;
            end
            S_POW_T: begin
                n_pt = r_rem; n_e = {1'b0, r_e[63:1]}; n_state = S_POW;
            end
            S_EUC: begin
                if (r_eb == '0) n_state = S_INV_FIX;
                else begin
                    n_dv = {r_ea, 34'd0}; n_cnt = 7'd30; n_rem = '0; n_dvs = r_eb;
                    n_ret = S_EUC_Q; n_state = S_DIV;
                end
            end
            S_EUC_Q: begin
                mul_x = {2'b0, r_dv[29:0]};
                mul_y = r_v;
                n_tv = mul_p[31:0];
                n_ea = r_eb; n_eb = r_rem; n_state = S_EUC_U;
            end
            S_EUC_U: begin
                n_u = r_v; n_v = r_u - $signed(r_tv); n_state = S_EUC;
            end
            S_INV_FIX: begin
                if (r_u < 0) n_inv = (fixm == '0) ? '0 : 30'(r_m - fixm);
                else         n_inv = fixm;
                n_res = n_inv;
                n_state = r_iret;
            end
            S_DIV2: begin
                n_x = r_a; n_y = r_inv; n_mret = S_FIN_REM; n_state = S_MUL;
            end
            S_DONE: begin
                n_ovld = 1'b1; n_out.result = r_res; n_out.equal = r_eq;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_m     <= MODULUS_RESET;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            if (i_cfg_we) r_m <= i_cfg_wdata;
        end
        r_ret <= n_ret; r_mret <= n_mret; r_iret <= n_iret;
        r_op <= n_op; r_a <= n_a; r_b <= n_b; r_w <= n_w; r_x <= n_x; r_y <= n_y;
        r_pr <= n_pr; r_pt <= n_pt; r_e <= n_e; r_ea <= n_ea; r_eb <= n_eb;
        r_u <= n_u; r_v <= n_v; r_tv <= n_tv; r_inv <= n_inv; r_res <= n_res;
        r_eq <= n_eq; r_dv <= n_dv; r_rem <= n_rem; r_dvs <= n_dvs; r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_ovld;
    assign o_rsp    = r_out;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && r_m >= 30'd2) |=> busy)
        else $error("request accepted without going busy");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 7'd0))
        else $error("divider running with zero step count");
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy || start))
        else $error("result strobe without a request");

endmodule
`default_nettype wire
